// ===== src/line_box_clipper_defines.svh =====
// Assertion macros shared by the checker.
`ifndef LINE_BOX_CLIPPER_DEFINES_SVH
`define LINE_BOX_CLIPPER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define LBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the cycle after the antecedent.
`define LBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== src/lbc_pkg.sv =====
`timescale 1ns / 1ps
package lbc_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    // Quotient limit: magnitudes above this only saturate.
    localparam int QUOT_BITS = 41;
    localparam int DIV_STEPS_PER_STAGE = 4;
endpackage

// ===== src/lbc_if.sv =====
`timescale 1ns / 1ps
interface lbc_if #(
    parameter int W = 32,
    parameter int N = 8
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] data [N];
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/line_box_clipper.sv =====
`timescale 1ns / 1ps
// Line-to-box clipper. One item (line through two points, box edges)
// enters per cycle unless the output stalls, and passes through a setup
// stage, a product stage, a restoring-divider stage chain (four quotient
// bits per stage over the full product width), then a select stage.
// Stalls freeze the whole pipeline; the output register is the last stage.
module line_box_clipper
    import lbc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)(
    input  logic clk,
    input  logic rst_n,
    lbc_if.sink   in_ch,
    lbc_if.source out_ch
);
    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 2;          // differences
    localparam int PW = 2 * DW;         // product magnitude
    localparam int NS = (PW + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
    localparam int NB = NS * DIV_STEPS_PER_STAGE;
    localparam int RW = DW + 1;
    // one spare bit so a capped quotient survives the next shift
    localparam int QW = QUOT_BITS + 1;
    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [QW-1:0] QCAP = {2'b01, {(QUOT_BITS-1){1'b0}}};
    localparam int L = NS + 3;

    // Per-item context
    typedef struct packed {
        logic signed [W-1:0] bl, br, bb, bt;
        logic                lx, by, enx, eny;
    } ctx_t;

    // One intersection job: base + a*b/c
    typedef struct packed {
        logic signed [W-1:0] base;
        logic                neg;
        logic [DW-1:0]       c;
        logic [NB-1:0]       num;
        logic [RW-1:0]       r;
        logic [QW-1:0]       q;
    } job_t;

    logic              adv;
    logic [L-1:0]      v_reg;
    ctx_t              ctx_reg [NS+2];
    job_t              job_reg [NS+2][4];
    logic [DW-1:0]     ma_reg [4], mb_reg [4];
    logic signed [W-1:0] res_reg [4];

    assign adv = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;
    assign out_ch.valid = v_reg[L-1];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[L-2:0], in_ch.valid};
        end
    end

    function automatic logic [DW-1:0] absv(input logic signed [DW-1:0] v);
        begin
            absv = v[DW-1] ? DW'(-v) : v;
        end
    endfunction

    // Stage 0: differences, signs and magnitudes
    logic signed [DW-1:0] dx, dy, na [4], nb [4], nc [4];
    always_comb
    begin
        dx = DW'(in_ch.data[2]) - DW'(in_ch.data[0]);
        dy = DW'(in_ch.data[3]) - DW'(in_ch.data[1]);
        na[0] = DW'(in_ch.data[4]) - DW'(in_ch.data[0]);
        na[1] = DW'(in_ch.data[5]) - DW'(in_ch.data[0]);
        na[2] = DW'(in_ch.data[6]) - DW'(in_ch.data[1]);
        na[3] = DW'(in_ch.data[7]) - DW'(in_ch.data[1]);
        for (int k = 0; k < 4; k++)
        begin
            nb[k] = (k < 2) ? dy : dx;
            nc[k] = (k < 2) ? dx : dy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg[0].bl  <= in_ch.data[4];
            ctx_reg[0].br  <= in_ch.data[5];
            ctx_reg[0].bb  <= in_ch.data[6];
            ctx_reg[0].bt  <= in_ch.data[7];
            ctx_reg[0].lx  <= in_ch.data[0] < in_ch.data[2];
            ctx_reg[0].by  <= in_ch.data[1] < in_ch.data[3];
            ctx_reg[0].enx <= dx != '0 && in_ch.data[6] != in_ch.data[7];
            ctx_reg[0].eny <= dy != '0 && in_ch.data[4] != in_ch.data[5];
            for (int k = 0; k < 4; k++)
            begin
                job_reg[0][k].base <= (k < 2) ? in_ch.data[1] : in_ch.data[0];
                job_reg[0][k].neg  <= na[k][DW-1] ^ nb[k][DW-1] ^ nc[k][DW-1];
                job_reg[0][k].c    <= absv(nc[k]);
                job_reg[0][k].num  <= '0;
                job_reg[0][k].r    <= '0;
                job_reg[0][k].q    <= '0;
                ma_reg[k] <= absv(na[k]);
                mb_reg[k] <= absv(nb[k]);
            end
        end
    end

    // Stage 1: products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg[1] <= ctx_reg[0];
            for (int k = 0; k < 4; k++)
            begin
                job_reg[1][k].base <= job_reg[0][k].base;
                job_reg[1][k].neg  <= job_reg[0][k].neg;
                job_reg[1][k].c    <= job_reg[0][k].c;
                job_reg[1][k].num  <= NB'(ma_reg[k]) * NB'(mb_reg[k]);
                job_reg[1][k].r    <= job_reg[0][k].r;
                job_reg[1][k].q    <= job_reg[0][k].q;
            end
        end
    end

    // Stages 2..NS+1: restoring division, four quotient bits per stage
    for (genvar s = 2; s < NS + 2; s++)
    begin : g_div
        job_t nxt [4];
        always_comb
        begin
            for (int k = 0; k < 4; k++)
            begin
                nxt[k] = job_reg[s-1][k];
                for (int i = 0; i < DIV_STEPS_PER_STAGE; i++)
                begin
                    nxt[k].r   = {nxt[k].r[RW-2:0], nxt[k].num[NB-1]};
                    nxt[k].num = {nxt[k].num[NB-2:0], 1'b0};
                    nxt[k].q   = {nxt[k].q[QW-2:0], 1'b0};
                    if (nxt[k].r >= RW'(nxt[k].c))
                    begin
                        nxt[k].r    = nxt[k].r - RW'(nxt[k].c);
                        nxt[k].q[0] = 1'b1;
                    end
                    if (nxt[k].q > QCAP)
                    begin
                        nxt[k].q = QCAP;
                    end
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ctx_reg[s] <= ctx_reg[s-1];
                for (int k = 0; k < 4; k++)
                begin
                    job_reg[s][k] <= nxt[k];
                end
            end
        end
    end

    // Final stage: apply sign, truncate, saturate, select points
    logic signed [QUOT_BITS+1:0] vv [4];
    logic signed [W-1:0]        pv [4];
    logic signed [W-1:0]        sx, sy, ex, ey;
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            vv[k] = job_reg[NS+1][k].neg
                  ? (QUOT_BITS+2)'(job_reg[NS+1][k].base) - (QUOT_BITS+2)'(job_reg[NS+1][k].q)
                  : (QUOT_BITS+2)'(job_reg[NS+1][k].base) + (QUOT_BITS+2)'(job_reg[NS+1][k].q);
            if (job_reg[NS+1][k].r != '0)
            begin
                if (!job_reg[NS+1][k].neg && vv[k] < 0)
                    vv[k] = vv[k] + 1'b1;
                else if (job_reg[NS+1][k].neg && vv[k] > 0)
                    vv[k] = vv[k] - 1'b1;
            end
            if (vv[k] > (QUOT_BITS+2)'(CMAX))
                pv[k] = CMAX;
            else if (vv[k] < (QUOT_BITS+2)'(CMIN))
                pv[k] = CMIN;
            else
                pv[k] = W'(vv[k]);
        end
    end

    always_comb
    begin
        ctx_t c;
        logic signed [W-1:0] p0x, p0y, p1x, p1y;
        c = ctx_reg[NS+1];
        // point 0 is start, point 1 is end
        p0x = c.lx ? CMIN : CMAX;
        p1x = c.lx ? CMAX : CMIN;
        p0y = c.by ? CMIN : CMAX;
        p1y = c.by ? CMAX : CMIN;
        if (c.enx)
        begin
            if (c.lx)
            begin
                if (c.bl > p0x) begin p0x = c.bl; p0y = pv[0]; end
                if (c.br < p1x) begin p1x = c.br; p1y = pv[1]; end
            end
            else
            begin
                if (c.bl > p1x) begin p1x = c.bl; p1y = pv[0]; end
                if (c.br < p0x) begin p0x = c.br; p0y = pv[1]; end
            end
        end
        if (c.eny)
        begin
            if (c.by)
            begin
                if (c.bb > p0y) begin p0y = c.bb; p0x = pv[2]; end
                if (c.bt < p1y) begin p1y = c.bt; p1x = pv[3]; end
            end
            else
            begin
                if (c.bb > p1y) begin p1y = c.bb; p1x = pv[2]; end
                if (c.bt < p0y) begin p0y = c.bt; p0x = pv[3]; end
            end
        end
        sx = p0x;
        sy = p0y;
        ex = p1x;
        ey = p1y;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg[0] <= sx;
            res_reg[1] <= sy;
            res_reg[2] <= ex;
            res_reg[3] <= ey;
        end
    end

    assign out_ch.data = res_reg;
endmodule

// ===== src/lbc_checker.sv =====
`timescale 1ns / 1ps
`include "line_box_clipper_defines.svh"
module lbc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    // Stalled result must stay offered.
    `LBC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
    // Input side is open whenever the output is empty.
    `LBC_ASSERT_IMP(a_open, clk, rst_n, !out_valid, in_ready, "blocked while empty")
    // A stalled output blocks intake.
    `LBC_ASSERT_IMP(a_block, clk, rst_n, out_valid && !out_ready, !in_ready, "took item under stall")
endmodule

bind line_box_clipper lbc_checker u_lbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready)
);
